>>> sv/sgr_attribute_decoder_top_defines.svh
// Assertion macros for the SGR attribute decoder.
`ifndef SGR_ATTRIBUTE_DECODER_TOP_DEFINES_SVH
`define SGR_ATTRIBUTE_DECODER_TOP_DEFINES_SVH

`ifndef SYNTHESIS

// same-cycle implication
`define SGR_ASSERT_IMP(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sgr: same-cycle check failed");

// next-cycle implication
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sgr: next-cycle check failed");

`else

`define SGR_ASSERT_IMP(label, clk, rst, ante, cons)
`define SGR_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

>>> sv/sgr_pkg.sv
// Shared types, codes and constants of the SGR attribute decoder.
package sgr_pkg;

   localparam int PAGE_COUNT_DEFAULT = 16;
   localparam int PAGE_W = 4;
   localparam int PAGE_IN_COUNT = 2 ** PAGE_W;
   localparam int PARAM_W = 8;
   localparam int ATTR_W = 22;
   localparam int REQ_DATA_W = 16;
   localparam int RSP_DATA_W = 32;

   // SGR codes
   localparam logic [7:0] SGR_RESET_ALL = 8'd0;
   localparam logic [7:0] SGR_BOLD_ON = 8'd1;
   localparam logic [7:0] SGR_ULINE_ON = 8'd4;
   localparam logic [7:0] SGR_BLINK_ON = 8'd5;
   localparam logic [7:0] SGR_REVERSE_ON = 8'd7;
   localparam logic [7:0] SGR_BOLD_OFF = 8'd22;
   localparam logic [7:0] SGR_ULINE_OFF = 8'd24;
   localparam logic [7:0] SGR_BLINK_OFF = 8'd25;
   localparam logic [7:0] SGR_REVERSE_OFF = 8'd27;
   localparam logic [7:0] SGR_FG_BASE = 8'd30;
   localparam logic [7:0] SGR_FG_EXT = 8'd38;
   localparam logic [7:0] SGR_FG_DEFAULT = 8'd39;
   localparam logic [7:0] SGR_BG_BASE = 8'd40;
   localparam logic [7:0] SGR_BG_EXT = 8'd48;
   localparam logic [7:0] SGR_BG_DEFAULT = 8'd49;
   localparam logic [7:0] SGR_FG_BRIGHT = 8'd90;
   localparam logic [7:0] SGR_BG_BRIGHT = 8'd100;
   localparam logic [7:0] SGR_EXT_INDEXED = 8'd5;
   localparam logic [7:0] SGR_COLOR_SPAN = 8'd7;
   localparam logic [7:0] SGR_BRIGHT_OFFSET = 8'd8;

   // configuration register indexes
   localparam logic [0:0] CSR_INDEXED_EN = 1'b0;
   localparam logic [0:0] CSR_BRIGHT_EN = 1'b1;

   typedef struct packed {
      logic [7:0] bg_index;
      logic       bg_is_default;
      logic [7:0] fg_index;
      logic       fg_is_default;
      logic       reverse;
      logic       blink;
      logic       underline;
      logic       bold;
   } attr_type;

   localparam attr_type ATTR_RESET = '{
      bg_index: 8'd0, bg_is_default: 1'b1, fg_index: 8'd0, fg_is_default: 1'b1,
      reverse: 1'b0, blink: 1'b0, underline: 1'b0, bold: 1'b0};

   typedef enum logic [1:0] {
      LA_IDLE      = 2'd0,
      LA_SAW_INTRO = 2'd1,
      LA_SAW_FIVE  = 2'd2
   } la_phase_type;

   typedef struct packed {
      la_phase_type phase;
      logic         is_bg;
   } la_state_type;

   typedef struct packed {
      logic indexed_en;
      logic bright_en;
   } cfg_type;

endpackage

>>> sv/sgr_ram.sv
// Generic single-write, single-read RAM with registered read data.
module sgr_ram #(
   parameter int WIDTH = sgr_pkg::ATTR_W,
   parameter int DEPTH = sgr_pkg::PAGE_COUNT_DEFAULT,
   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic             clock,
   input  logic             wr_en,
   input  logic [AW-1:0]    wr_addr,
   input  logic [WIDTH-1:0] wr_data,
   input  logic             rd_en,
   input  logic [AW-1:0]    rd_addr,
   output logic [WIDTH-1:0] rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // read-first on an address collision
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> sv/sgr_decode.sv
// Decodes one SGR parameter against a page's attribute word and the lookahead state.
module sgr_decode (
   input  sgr_pkg::attr_type     word_in,
   input  logic [7:0]            param,
   input  logic                  last_param,
   input  logic                  empty_sequence,
   input  sgr_pkg::la_state_type la_in,
   input  sgr_pkg::cfg_type      cfg,
   output sgr_pkg::attr_type     word_out,
   output sgr_pkg::la_state_type la_out
);

   sgr_pkg::attr_type plain_word;
   logic              plain_start;

   // ordinary code, no lookahead pending
   always_comb begin
      plain_word = word_in;
      plain_start = 1'b0;
      unique case (param)
         sgr_pkg::SGR_RESET_ALL:   plain_word = sgr_pkg::ATTR_RESET;
         sgr_pkg::SGR_BOLD_ON:     plain_word.bold = 1'b1;
         sgr_pkg::SGR_ULINE_ON:    plain_word.underline = 1'b1;
         sgr_pkg::SGR_BLINK_ON:    plain_word.blink = 1'b1;
         sgr_pkg::SGR_REVERSE_ON:  plain_word.reverse = 1'b1;
         sgr_pkg::SGR_BOLD_OFF:    plain_word.bold = 1'b0;
         sgr_pkg::SGR_ULINE_OFF:   plain_word.underline = 1'b0;
         sgr_pkg::SGR_BLINK_OFF:   plain_word.blink = 1'b0;
         sgr_pkg::SGR_REVERSE_OFF: plain_word.reverse = 1'b0;
         sgr_pkg::SGR_FG_DEFAULT: begin
            plain_word.fg_is_default = 1'b1;
            plain_word.fg_index = 8'd0;
         end
         sgr_pkg::SGR_BG_DEFAULT: begin
            plain_word.bg_is_default = 1'b1;
            plain_word.bg_index = 8'd0;
         end
         sgr_pkg::SGR_FG_EXT, sgr_pkg::SGR_BG_EXT: begin
            plain_start = cfg.indexed_en && !last_param;
         end
         default: begin
            if (param >= sgr_pkg::SGR_FG_BASE &&
                param <= sgr_pkg::SGR_FG_BASE + sgr_pkg::SGR_COLOR_SPAN) begin
               plain_word.fg_is_default = 1'b0;
               plain_word.fg_index = param - sgr_pkg::SGR_FG_BASE;
            end else if (param >= sgr_pkg::SGR_BG_BASE &&
                         param <= sgr_pkg::SGR_BG_BASE + sgr_pkg::SGR_COLOR_SPAN) begin
               plain_word.bg_is_default = 1'b0;
               plain_word.bg_index = param - sgr_pkg::SGR_BG_BASE;
            end else if (cfg.bright_en && param >= sgr_pkg::SGR_FG_BRIGHT &&
                         param <= sgr_pkg::SGR_FG_BRIGHT + sgr_pkg::SGR_COLOR_SPAN) begin
               plain_word.fg_is_default = 1'b0;
               plain_word.fg_index = param - sgr_pkg::SGR_FG_BRIGHT + sgr_pkg::SGR_BRIGHT_OFFSET;
            end else if (cfg.bright_en && param >= sgr_pkg::SGR_BG_BRIGHT &&
                         param <= sgr_pkg::SGR_BG_BRIGHT + sgr_pkg::SGR_COLOR_SPAN) begin
               plain_word.bg_is_default = 1'b0;
               plain_word.bg_index = param - sgr_pkg::SGR_BG_BRIGHT + sgr_pkg::SGR_BRIGHT_OFFSET;
            end
         end
      endcase
   end

   always_comb begin
      word_out = word_in;
      la_out = la_in;
      if (empty_sequence) begin
         word_out = sgr_pkg::ATTR_RESET;
         la_out.phase = sgr_pkg::LA_IDLE;
      end else begin
         unique case (la_in.phase)
            sgr_pkg::LA_SAW_FIVE: begin
               // third word of 38;5;n / 48;5;n is always the index
               if (la_in.is_bg) begin
                  word_out.bg_is_default = 1'b0;
                  word_out.bg_index = param;
               end else begin
                  word_out.fg_is_default = 1'b0;
                  word_out.fg_index = param;
               end
               la_out.phase = sgr_pkg::LA_IDLE;
            end
            sgr_pkg::LA_SAW_INTRO: begin
               if (param == sgr_pkg::SGR_EXT_INDEXED && !last_param) begin
                  la_out.phase = sgr_pkg::LA_SAW_FIVE;
               end else begin
                  // broken lookahead: decode as an ordinary code
                  word_out = plain_word;
                  la_out.phase = plain_start ? sgr_pkg::LA_SAW_INTRO : sgr_pkg::LA_IDLE;
                  if (plain_start) begin
                     la_out.is_bg = (param == sgr_pkg::SGR_BG_EXT);
                  end
               end
            end
            default: begin
               word_out = plain_word;
               la_out.phase = plain_start ? sgr_pkg::LA_SAW_INTRO : sgr_pkg::LA_IDLE;
               if (plain_start) begin
                  la_out.is_bg = (param == sgr_pkg::SGR_BG_EXT);
               end
            end
         endcase
      end
   end

endmodule

>>> sv/sgr_attribute_decoder_top.sv
// Top level of the SGR attribute decoder: page store, decode stage and result register.
// An accepted word is held in the input stage (s1) and its result word in the result register.
// Throughput: one word per cycle unless rsp_tready stalls; the page RAM read is registered
// with the input stage, and a bypass register covers a write-back to the page that the next
// word reads. Reset clears lookahead state, page valid bits (pages read as reset word) and
// the stage and output valid flags (not rsp_tdata); both enables reset to 1. No clearing pass.
`include "sgr_attribute_decoder_top_defines.svh"

module sgr_attribute_decoder_top #(
   parameter int PAGE_COUNT = sgr_pkg::PAGE_COUNT_DEFAULT
) (
   input  logic        clock,
   input  logic        reset,
   // req_tdata: [3:0] page, [11:4] param, [15:12] zero
   input  logic [sgr_pkg::REQ_DATA_W-1:0] req_tdata,
   input  logic        req_tlast,   // last_param
   input  logic        req_tuser,   // empty_sequence
   input  logic        req_tvalid,
   output logic        req_tready,
   // rsp_tdata: [3:0] out_page, [4] bold, [5] underline, [6] blink, [7] reverse,
   //   [8] fg_is_default, [16:9] fg_index, [17] bg_is_default, [25:18] bg_index, [31:26] zero
   output logic [sgr_pkg::RSP_DATA_W-1:0] rsp_tdata,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic        csr_we,
   input  logic [0:0]  csr_index,
   input  logic        csr_wdata
);

   localparam int PG_W = (PAGE_COUNT > 1) ? $clog2(PAGE_COUNT) : 1;
   localparam int PAD_W = sgr_pkg::RSP_DATA_W - sgr_pkg::ATTR_W - sgr_pkg::PAGE_W;

   // page reduction table
   logic [PG_W-1:0] page_red_tbl [sgr_pkg::PAGE_IN_COUNT];
   for (genvar g = 0; g < sgr_pkg::PAGE_IN_COUNT; g++) begin : g_page_tbl
      assign page_red_tbl[g] = PG_W'(g % PAGE_COUNT);
   end

   logic [PG_W-1:0]   page_red;
   logic              req_acc;
   logic              s1_adv;

   logic              s1_valid_ff, s1_valid_in;
   logic [PG_W-1:0]   s1_page_ff;
   logic [7:0]        s1_param_ff;
   logic              s1_last_ff;
   logic              s1_empty_ff;
   logic              s1_vld_ff;
   logic              fwd_hit_ff, fwd_hit_in;
   sgr_pkg::attr_type fwd_word_ff;

   logic [PAGE_COUNT-1:0] valid_bits_ff, valid_bits_in;
   sgr_pkg::la_state_type la_ff, la_nx;
   sgr_pkg::cfg_type      cfg_ff, cfg_in;

   logic                           rsp_valid_ff, rsp_valid_in;
   logic [sgr_pkg::RSP_DATA_W-1:0] rsp_data_ff;

   logic [sgr_pkg::ATTR_W-1:0] ram_rd_data;
   sgr_pkg::attr_type          cur_word;
   sgr_pkg::attr_type          new_word;

   assign page_red = page_red_tbl[req_tdata[sgr_pkg::PAGE_W-1:0]];
   assign s1_adv = s1_valid_ff && (!rsp_valid_ff || rsp_tready);
   assign req_tready = !s1_valid_ff || s1_adv;
   assign req_acc = req_tvalid && req_tready;

   sgr_ram #(
      .WIDTH(sgr_pkg::ATTR_W),
      .DEPTH(PAGE_COUNT)
   ) u_page_ram (
      .clock   (clock),
      .wr_en   (s1_adv),
      .wr_addr (s1_page_ff),
      .wr_data (new_word),
      .rd_en   (req_acc),
      .rd_addr (page_red),
      .rd_data (ram_rd_data)
   );

   // a word written back in the same edge the next word read the RAM wins
   always_comb begin
      if (fwd_hit_ff) begin
         cur_word = fwd_word_ff;
      end else if (s1_vld_ff) begin
         cur_word = sgr_pkg::attr_type'(ram_rd_data);
      end else begin
         cur_word = sgr_pkg::ATTR_RESET;
      end
   end

   sgr_decode u_decode (
      .word_in        (cur_word),
      .param          (s1_param_ff),
      .last_param     (s1_last_ff),
      .empty_sequence (s1_empty_ff),
      .la_in          (la_ff),
      .cfg            (cfg_ff),
      .word_out       (new_word),
      .la_out         (la_nx)
   );

   always_comb begin
      s1_valid_in = s1_valid_ff;
      if (req_acc) begin
         s1_valid_in = 1'b1;
      end else if (s1_adv) begin
         s1_valid_in = 1'b0;
      end
      fwd_hit_in = s1_adv && (s1_page_ff == page_red);
      valid_bits_in = valid_bits_ff;
      if (s1_adv) begin
         valid_bits_in[s1_page_ff] = 1'b1;
      end
      rsp_valid_in = s1_adv || (rsp_valid_ff && !rsp_tready);
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_index)
            sgr_pkg::CSR_INDEXED_EN: cfg_in.indexed_en = csr_wdata;
            sgr_pkg::CSR_BRIGHT_EN:  cfg_in.bright_en = csr_wdata;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         fwd_hit_ff <= 1'b0;
         valid_bits_ff <= '0;
         la_ff <= '{phase: sgr_pkg::LA_IDLE, is_bg: 1'b0};
         cfg_ff <= '{indexed_en: 1'b1, bright_en: 1'b1};
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         valid_bits_ff <= valid_bits_in;
         cfg_ff <= cfg_in;
         rsp_valid_ff <= rsp_valid_in;
         if (req_acc) begin
            fwd_hit_ff <= fwd_hit_in;
         end
         if (s1_adv) begin
            la_ff <= la_nx;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_acc) begin
         s1_page_ff <= page_red;
         s1_param_ff <= req_tdata[sgr_pkg::PAGE_W +: sgr_pkg::PARAM_W];
         s1_last_ff <= req_tlast;
         s1_empty_ff <= req_tuser;
         s1_vld_ff <= valid_bits_ff[page_red];
         fwd_word_ff <= new_word;
      end
      if (s1_adv) begin
         rsp_data_ff <= {PAD_W'(0), new_word, sgr_pkg::PAGE_W'(s1_page_ff)};
      end
   end

   assign rsp_tdata = rsp_data_ff;
   assign rsp_tvalid = rsp_valid_ff;

   `SGR_ASSERT_IMP(a_rsp_from_stage, clock, reset, $rose(rsp_tvalid), $past(s1_adv))
   `SGR_ASSERT_IMP(a_five_after_intro, clock, reset, s1_adv && la_nx.phase == sgr_pkg::LA_SAW_FIVE, la_ff.phase == sgr_pkg::LA_SAW_INTRO)
   `SGR_ASSERT_NEXT(a_empty_resets, clock, reset, s1_adv && s1_empty_ff, rsp_data_ff[25:4] == sgr_pkg::ATTR_RESET)

endmodule

>>> tb/sv/sgr_attribute_decoder_top_tb.sv
// Self-checking testbench for sgr_attribute_decoder_top: directed and random SGR traffic.
module sgr_attribute_decoder_top_tb;
   import sgr_pkg::*;

   localparam int ITEM_COUNT     = 2000;
   localparam int DRAIN_CYCLES   = 4;
   localparam int WATCHDOG_LIMIT = 2000;

   typedef struct {
      logic [PAGE_W-1:0] page;
      attr_type          attr;
   } page_attr_t;

   typedef enum logic [1:0] {
      RDY_ALWAYS,
      RDY_COIN,
      RDY_DUTY
   } rdy_mode_t;

   logic                  clock      = 1'b0;
   logic                  reset      = 1'b1;
   logic [REQ_DATA_W-1:0] req_tdata  = '0;
   logic                  req_tlast  = 1'b0;
   logic                  req_tuser  = 1'b0;
   logic                  req_tvalid = 1'b0;
   logic                  req_tready;
   logic [RSP_DATA_W-1:0] rsp_tdata;
   logic                  rsp_tvalid;
   logic                  rsp_tready = 1'b0;
   logic                  csr_we     = 1'b0;
   logic [0:0]            csr_index  = CSR_INDEXED_EN;
   logic                  csr_wdata  = 1'b0;

   // predicted decoder state
   attr_type     page_word [PAGE_IN_COUNT];
   la_phase_type ext_phase;
   logic         ext_is_bg;
   cfg_type      cfg_shadow;

   page_attr_t pending_attrs [$];
   int         mismatches   = 0;
   int         words_sent   = 0;
   int         burst_left   = 0;
   int         quiet_cycles = 0;

   rdy_mode_t rsp_mode      = RDY_ALWAYS;
   int        rsp_mode_left = 0;
   int        rsp_cycle     = 0;

   logic [7:0] flag_codes [0:7] = '{SGR_BOLD_ON, SGR_ULINE_ON, SGR_BLINK_ON, SGR_REVERSE_ON,
      SGR_BOLD_OFF, SGR_ULINE_OFF, SGR_BLINK_OFF, SGR_REVERSE_OFF};

   sgr_attribute_decoder_top u_dut (
      .clock      (clock),
      .reset      (reset),
      .req_tdata  (req_tdata),
      .req_tlast  (req_tlast),
      .req_tuser  (req_tuser),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .csr_we     (csr_we),
      .csr_index  (csr_index),
      .csr_wdata  (csr_wdata)
   );

   always #6 clock = ~clock;

   function automatic attr_type put_colour(attr_type a, logic bg, logic dflt, logic [7:0] idx);
      if (bg) begin
         a.bg_is_default = dflt;
         a.bg_index      = dflt ? 8'd0 : idx;
      end else begin
         a.fg_is_default = dflt;
         a.fg_index      = dflt ? 8'd0 : idx;
      end
      return a;
   endfunction

   // plain code decode; 38/48 may open the indexed-colour lookahead
   function automatic attr_type decode_code(attr_type a, logic [7:0] p, logic lst);
      case (p)
         SGR_RESET_ALL:   a = ATTR_RESET;
         SGR_BOLD_ON:     a.bold = 1'b1;
         SGR_ULINE_ON:    a.underline = 1'b1;
         SGR_BLINK_ON:    a.blink = 1'b1;
         SGR_REVERSE_ON:  a.reverse = 1'b1;
         SGR_BOLD_OFF:    a.bold = 1'b0;
         SGR_ULINE_OFF:   a.underline = 1'b0;
         SGR_BLINK_OFF:   a.blink = 1'b0;
         SGR_REVERSE_OFF: a.reverse = 1'b0;
         SGR_FG_DEFAULT:  a = put_colour(a, 1'b0, 1'b1, 8'd0);
         SGR_BG_DEFAULT:  a = put_colour(a, 1'b1, 1'b1, 8'd0);
         SGR_FG_EXT, SGR_BG_EXT: begin
            if (cfg_shadow.indexed_en && !lst) begin
               ext_phase = LA_SAW_INTRO;
               ext_is_bg = (p == SGR_BG_EXT);
            end
         end
         default: begin
            if (p >= SGR_FG_BASE && p <= SGR_FG_BASE + SGR_COLOR_SPAN)
               a = put_colour(a, 1'b0, 1'b0, p - SGR_FG_BASE);
            else if (p >= SGR_BG_BASE && p <= SGR_BG_BASE + SGR_COLOR_SPAN)
               a = put_colour(a, 1'b1, 1'b0, p - SGR_BG_BASE);
            else if (cfg_shadow.bright_en && p >= SGR_FG_BRIGHT
                     && p <= SGR_FG_BRIGHT + SGR_COLOR_SPAN)
               a = put_colour(a, 1'b0, 1'b0, SGR_BRIGHT_OFFSET + (p - SGR_FG_BRIGHT));
            else if (cfg_shadow.bright_en && p >= SGR_BG_BRIGHT
                     && p <= SGR_BG_BRIGHT + SGR_COLOR_SPAN)
               a = put_colour(a, 1'b1, 1'b0, SGR_BRIGHT_OFFSET + (p - SGR_BG_BRIGHT));
         end
      endcase
      return a;
   endfunction

   function automatic void predict_attr(logic [PAGE_W-1:0] pg, logic [7:0] prm, logic lst,
                                        logic emp);
      attr_type   a;
      page_attr_t e;
      a = page_word[pg];
      if (emp) begin
         a         = ATTR_RESET;
         ext_phase = LA_IDLE;
      end else if (ext_phase == LA_SAW_FIVE) begin
         a         = put_colour(a, ext_is_bg, 1'b0, prm);
         ext_phase = LA_IDLE;
      end else if (ext_phase == LA_SAW_INTRO) begin
         if (prm == SGR_EXT_INDEXED && !lst) begin
            ext_phase = LA_SAW_FIVE;
         end else begin
            ext_phase = LA_IDLE;
            a         = decode_code(a, prm, lst);
         end
      end else begin
         a = decode_code(a, prm, lst);
      end
      page_word[pg] = a;
      e.page = pg;
      e.attr = a;
      pending_attrs.push_back(e);
   endfunction

   function automatic void check_field(string name, logic [7:0] exp_v, logic [7:0] act_v);
      if (exp_v !== act_v) begin
         $error("%s: expected %0d, got %0d", name, exp_v, act_v);
         mismatches++;
      end
   endfunction

   // sender: bursts of random length separated by random gaps
   task automatic send_word(input logic [PAGE_W-1:0] pg, input logic [7:0] prm,
                            input logic lst, input logic emp);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
         if (gap > 0) begin
            req_tvalid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
         burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(30, 120)
                                                  : $urandom_range(1, 10);
      end
      burst_left--;
      req_tdata  <= {4'd0, prm, pg};
      req_tlast  <= lst;
      req_tuser  <= emp;
      req_tvalid <= 1'b1;
      do @(posedge clock); while (!req_tready);
      predict_attr(pg, prm, lst, emp);
      words_sent++;
   endtask

   task automatic wait_results_done();
      req_tvalid <= 1'b0;
      while (pending_attrs.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic set_config(input logic idx_en, input logic br_en);
      wait_results_done();
      csr_we    <= 1'b1;
      csr_index <= CSR_INDEXED_EN;
      csr_wdata <= idx_en;
      @(posedge clock);
      cfg_shadow.indexed_en = idx_en;
      csr_index <= CSR_BRIGHT_EN;
      csr_wdata <= br_en;
      @(posedge clock);
      cfg_shadow.bright_en = br_en;
      csr_we <= 1'b0;
   endtask

   task automatic test_flag_codes();
      send_word(4'd0, SGR_BOLD_ON, 1'b0, 1'b0);
      send_word(4'd0, SGR_ULINE_ON, 1'b0, 1'b0);
      send_word(4'd0, SGR_BLINK_ON, 1'b0, 1'b0);
      send_word(4'd0, SGR_REVERSE_ON, 1'b0, 1'b0);
      send_word(4'd0, SGR_BOLD_OFF, 1'b0, 1'b0);
      send_word(4'd0, SGR_ULINE_OFF, 1'b0, 1'b0);
      send_word(4'd0, SGR_BLINK_OFF, 1'b0, 1'b0);
      send_word(4'd0, SGR_REVERSE_OFF, 1'b1, 1'b0);
   endtask

   task automatic test_colour_codes();
      send_word(4'd15, SGR_FG_BASE, 1'b0, 1'b0);
      send_word(4'd15, SGR_BG_BASE + SGR_COLOR_SPAN, 1'b0, 1'b0);
      send_word(4'd15, SGR_FG_BRIGHT + SGR_COLOR_SPAN, 1'b0, 1'b0);
      send_word(4'd15, SGR_BG_BRIGHT, 1'b0, 1'b0);
      send_word(4'd15, SGR_FG_DEFAULT, 1'b0, 1'b0);
      send_word(4'd15, SGR_BG_DEFAULT, 1'b0, 1'b0);
      send_word(4'd15, SGR_RESET_ALL, 1'b1, 1'b0);
   endtask

   task automatic test_indexed_lookahead();
      send_word(4'd3, SGR_FG_EXT, 1'b0, 1'b0);
      send_word(4'd3, SGR_EXT_INDEXED, 1'b0, 1'b0);
      send_word(4'd3, 8'd255, 1'b1, 1'b0);
      // lookahead spans pages; index arrives as the last parameter
      send_word(4'd1, SGR_BG_EXT, 1'b0, 1'b0);
      send_word(4'd2, SGR_EXT_INDEXED, 1'b0, 1'b0);
      send_word(4'd4, 8'd0, 1'b1, 1'b0);
      send_word(4'd5, SGR_FG_EXT, 1'b1, 1'b0);
      // 5 as last param breaks the lookahead and decodes as blink
      send_word(4'd6, SGR_BG_EXT, 1'b0, 1'b0);
      send_word(4'd6, SGR_EXT_INDEXED, 1'b1, 1'b0);
      // empty sequence drops the pending lookahead
      send_word(4'd7, SGR_FG_EXT, 1'b0, 1'b0);
      send_word(4'd7, 8'd255, 1'b1, 1'b1);
      send_word(4'd7, SGR_EXT_INDEXED, 1'b1, 1'b0);
   endtask

   task automatic test_config_mid_lookahead();
      send_word(4'd8, SGR_FG_EXT, 1'b0, 1'b0);
      set_config(1'b0, 1'b0);
      send_word(4'd8, SGR_EXT_INDEXED, 1'b0, 1'b0);
      send_word(4'd8, 8'd9, 1'b0, 1'b0);
      send_word(4'd8, SGR_FG_BRIGHT + 8'd1, 1'b0, 1'b0);
      send_word(4'd8, SGR_BG_EXT, 1'b1, 1'b0);
   endtask

   // mostly well-formed sequences with random content
   task automatic send_random_sequence();
      logic [PAGE_W-1:0] pg;
      logic [7:0]        ext;
      logic [7:0]        codes [$];
      int                n;
      pg = 4'($urandom_range(0, 15));
      if ($urandom_range(0, 19) == 0) begin
         send_word(pg, 8'($urandom), 1'($urandom), 1'b1);
      end else begin
         n = $urandom_range(1, 4);
         repeat (n) begin
            ext = ($urandom_range(0, 1) == 1) ? SGR_BG_EXT : SGR_FG_EXT;
            case ($urandom_range(0, 8))
               0: codes.push_back(flag_codes[$urandom_range(0, 7)]);
               1: codes.push_back(SGR_FG_BASE + 8'($urandom_range(0, 7)));
               2: codes.push_back(SGR_BG_BASE + 8'($urandom_range(0, 7)));
               3: codes.push_back((($urandom_range(0, 1) == 1) ? SGR_BG_BRIGHT : SGR_FG_BRIGHT)
                                  + 8'($urandom_range(0, 7)));
               4: begin
                  case ($urandom_range(0, 2))
                     0:       codes.push_back(SGR_FG_DEFAULT);
                     1:       codes.push_back(SGR_BG_DEFAULT);
                     default: codes.push_back(SGR_RESET_ALL);
                  endcase
               end
               5, 6: begin
                  codes.push_back(ext);
                  codes.push_back(SGR_EXT_INDEXED);
                  codes.push_back(8'($urandom));
               end
               7: begin
                  // intro that the following code may break
                  codes.push_back(ext);
                  if ($urandom_range(0, 1) == 1) codes.push_back(SGR_EXT_INDEXED);
               end
               default: codes.push_back(8'($urandom));
            endcase
         end
         foreach (codes[i]) begin
            if ($urandom_range(0, 15) == 0) pg = 4'($urandom_range(0, 15));
            send_word(pg, codes[i], 1'(i == codes.size() - 1), 1'b0);
         end
      end
   endtask

   task automatic test_random_traffic(input logic idx_en, input logic br_en, input int n_items);
      int stop_at;
      set_config(idx_en, br_en);
      stop_at = words_sent + n_items;
      while (words_sent < stop_at) begin
         if ($urandom_range(0, 199) == 0) wait_results_done();
         if ($urandom_range(0, 9) == 0)
            send_word(4'($urandom), 8'($urandom), 1'($urandom),
                      1'($urandom_range(0, 3) == 0));
         else
            send_random_sequence();
      end
   endtask

   // receiver stall pattern
   always @(posedge clock) begin
      rsp_cycle <= rsp_cycle + 1;
      if (rsp_mode_left == 0) begin
         rsp_mode      <= rdy_mode_t'($urandom_range(0, 2));
         rsp_mode_left <= $urandom_range(20, 200);
      end else begin
         rsp_mode_left <= rsp_mode_left - 1;
      end
      case (rsp_mode)
         RDY_ALWAYS: rsp_tready <= 1'b1;
         RDY_COIN:   rsp_tready <= ($urandom_range(0, 3) != 0);
         default:    rsp_tready <= ((rsp_cycle % 5) < 2);
      endcase
   end

   always @(posedge clock) begin : check_rsp
      page_attr_t exp_w;
      attr_type   got;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = attr_type'(rsp_tdata[25:4]);
         if (pending_attrs.size() == 0) begin
            $error("unexpected result word %h", rsp_tdata);
            mismatches++;
         end else begin
            exp_w = pending_attrs.pop_front();
            check_field("out_page", 8'(exp_w.page), 8'(rsp_tdata[3:0]));
            check_field("bold", 8'(exp_w.attr.bold), 8'(got.bold));
            check_field("underline", 8'(exp_w.attr.underline), 8'(got.underline));
            check_field("blink", 8'(exp_w.attr.blink), 8'(got.blink));
            check_field("reverse", 8'(exp_w.attr.reverse), 8'(got.reverse));
            check_field("fg_is_default", 8'(exp_w.attr.fg_is_default), 8'(got.fg_is_default));
            check_field("fg_index", exp_w.attr.fg_index, got.fg_index);
            check_field("bg_is_default", 8'(exp_w.attr.bg_is_default), 8'(got.bg_is_default));
            check_field("bg_index", exp_w.attr.bg_index, got.bg_index);
            check_field("pad", 8'd0, 8'(rsp_tdata[31:26]));
         end
      end
   end

   // watchdog: cycles without any handshake
   always @(posedge clock) begin
      if ((req_tvalid && req_tready) || (rsp_tvalid && rsp_tready))
         quiet_cycles <= 0;
      else
         quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("RESULT: ERROR");
         $finish;
      end
   end

   initial begin
      foreach (page_word[i]) page_word[i] = ATTR_RESET;
      ext_phase  = LA_IDLE;
      ext_is_bg  = 1'b0;
      cfg_shadow = '{indexed_en: 1'b1, bright_en: 1'b1};
      repeat (9) @(posedge clock);
      reset <= 1'b0;

      test_flag_codes();
      test_colour_codes();
      test_indexed_lookahead();
      test_config_mid_lookahead();
      test_random_traffic(1'b1, 1'b1, ITEM_COUNT / 5);
      test_random_traffic(1'b0, 1'b1, ITEM_COUNT / 5);
      test_random_traffic(1'b1, 1'b0, ITEM_COUNT / 5);
      test_random_traffic(1'b0, 1'b0, ITEM_COUNT / 5);
      test_random_traffic(1'b1, 1'b1, ITEM_COUNT / 5);

      wait_results_done();
      if (mismatches == 0 && pending_attrs.size() == 0)
         $display("RESULT: OK");
      else
         $display("RESULT: ERROR");
      $finish;
   end

endmodule

>>> filelist.f
+incdir+sv
sv/sgr_pkg.sv
sv/sgr_ram.sv
sv/sgr_decode.sv
sv/sgr_attribute_decoder_top.sv
tb/sv/sgr_attribute_decoder_top_tb.sv
